// ===== design/smtr_pkg.sv =====
`default_nettype none

package smtr_pkg;

    // Mapper geometry
    localparam int SECTOR_COUNT = 8;
    localparam int SECTOR_BYTES = 8192;
    localparam int VRAM_FIRST   = 1024;
    localparam int VRAM_LAST    = 1025;

    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int IDX_W        = $clog2(SECTOR_COUNT);
    localparam int OFFSET_W     = 22;
    localparam int WINDOW_LEN   = 6;

    localparam logic [15:0] RAM_FIRST   = 16'd512;
    localparam logic [15:0] RAM_LAST    = 16'd1023;
    localparam logic [7:0]  MAPPER_PORT = 8'd2;
    localparam logic [7:0]  MARK_BYTE   = 8'hff;

    // Bus opcodes
    localparam logic [1:0] OP_MEM_READ  = 2'd0;
    localparam logic [1:0] OP_MEM_WRITE = 2'd1;
    localparam logic [1:0] OP_IO_WRITE  = 2'd2;

    // Target devices
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_ROM  = 2'd1;
    localparam logic [1:0] TGT_RAM  = 2'd2;
    localparam logic [1:0] TGT_VRAM = 2'd3;

    // Mapper command status
    localparam logic [1:0] MAP_NONE     = 2'd0;
    localparam logic [1:0] MAP_DONE     = 2'd1;
    localparam logic [1:0] MAP_REJECTED = 2'd2;

    // Map update from the command window to the sector table
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [15:0]      wr_value;
        logic [1:0]       status;
    } t_map_cmd;

    // Reset contents of one sector table entry
    function automatic logic [15:0] map_reset_value(input int idx);
        logic [15:0] value;
        value = 16'd0;
        if (idx == 1)
            value = RAM_FIRST;
        if (idx == SECTOR_COUNT - 1)
            value = 16'(VRAM_FIRST);
        return value;
    endfunction

endpackage

`default_nettype wire

// ===== design/sector_mapper_address_translator.sv =====
// Channel   Handshake              Payload
// -------   --------------------   ----------------------------------------------
// access    start / busy (in)      i_opcode, i_bus_address, i_bus_data
// result    o_valid strobe (out)   o_target, o_device_offset, o_write_strobe,
//                                  o_write_byte, o_map_status
//
// One transaction per clock; busy stays low, so start may be held every cycle.
// Each transaction passes the input register, then one pass of decode and table
// lookup into the result register; the sector table updates in that same pass.
// Synchronous active-low reset restores the sector table and clears the window.
// The receiver cannot stall: each result is on the ports for one cycle only.
`default_nettype none

module sector_mapper_address_translator
    import smtr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_opcode,
    input  wire logic [15:0]         i_bus_address,
    input  wire logic [7:0]          i_bus_data,
    output logic                     o_valid,
    output logic [1:0]               o_target,
    output logic [OFFSET_W-1:0]      o_device_offset,
    output logic                     o_write_strobe,
    output logic [7:0]               o_write_byte,
    output logic [1:0]               o_map_status
);

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_opcode;
    logic [15:0] r_address;
    logic [7:0]  r_data;

    // Sector table
    logic [15:0] r_sector_map [SECTOR_COUNT];

    // Result register
    logic                r_valid;
    logic [1:0]          r_target;
    logic [OFFSET_W-1:0] r_offset;
    logic                r_strobe;
    logic [7:0]          r_byte;
    logic [1:0]          r_status;

    logic [1:0]          n_target;
    logic [OFFSET_W-1:0] n_offset;
    logic                n_strobe;
    logic [7:0]          n_byte;

    logic                io_shift;
    t_map_cmd            map_cmd;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_opcode  <= i_opcode;
        r_address <= i_bus_address;
        r_data    <= i_bus_data;
    end

    // Mapper port writes feed the command window
    assign io_shift = r_in_valid && r_opcode == OP_IO_WRITE &&
                      r_address[7:0] == MAPPER_PORT;

    smtr_cmd_window u_cmd_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (io_shift),
        .i_data  (r_data),
        .o_cmd   (map_cmd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SECTOR_COUNT; i++)
                r_sector_map[i] <= map_reset_value(i);
        end else if (map_cmd.wr_en) begin
            r_sector_map[map_cmd.wr_idx] <= map_cmd.wr_value;
        end
    end

    // Address translation
    always_comb begin
        logic [16:0] sect;
        logic [15:0] hw;
        logic [15:0] base_diff;
        logic        is_write;
        logic        is_mem;
        sect      = {1'b0, r_address} >> SECTOR_SHIFT;
        hw        = r_sector_map[sect[IDX_W-1:0]];
        is_write  = r_opcode == OP_MEM_WRITE;
        is_mem    = r_opcode == OP_MEM_READ || is_write;
        base_diff = 16'd0;
        n_target  = TGT_NONE;
        n_strobe  = 1'b0;
        if (is_mem && sect < 17'(SECTOR_COUNT)) begin
            if (hw == 16'd0) begin
                n_target = TGT_ROM;
            end else if (hw >= RAM_FIRST && hw <= RAM_LAST) begin
                n_target  = TGT_RAM;
                base_diff = hw - RAM_FIRST;
                n_strobe  = is_write;
            end else if (hw >= 16'(VRAM_FIRST) && hw <= 16'(VRAM_LAST)) begin
                n_target  = TGT_VRAM;
                base_diff = hw - 16'(VRAM_FIRST);
                n_strobe  = is_write;
            end
        end
        n_offset = OFFSET_W'(r_address & 16'(SECTOR_BYTES - 1)) +
                   OFFSET_W'(32'(base_diff) << SECTOR_SHIFT);
        if (n_target == TGT_NONE)
            n_offset = '0;
        n_byte = n_strobe ? r_data : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_in_valid;
        end
        r_target <= n_target;
        r_offset <= n_offset;
        r_strobe <= n_strobe;
        r_byte   <= n_byte;
        r_status <= map_cmd.status;
    end

    assign o_valid         = r_valid;
    assign o_target        = r_target;
    assign o_device_offset = r_offset;
    assign o_write_strobe  = r_valid && r_strobe;
    assign o_write_byte    = r_byte;
    assign o_map_status    = r_status;

    // Checks
    a_strobe_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_strobe |-> (o_target == TGT_RAM || o_target == TGT_VRAM))
        else $error("write strobe without ram or video ram target");

    a_cmd_no_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_map_status != MAP_NONE) |-> (o_target == TGT_NONE &&
            !o_write_strobe))
        else $error("mapper command result carries a device access");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_valid)
        else $error("accepted transaction produced no result");

    a_map_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_cmd.wr_en |=> r_sector_map[$past(map_cmd.wr_idx)] == $past(map_cmd.wr_value))
        else $error("sector table not updated by remap command");

endmodule

`default_nettype wire

// ===== design/smtr_cmd_window.sv =====
`default_nettype none

module smtr_cmd_window
    import smtr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_shift,
    input  wire logic [7:0] i_data,
    output t_map_cmd      o_cmd
);

    logic [7:0] r_window [WINDOW_LEN];
    logic [7:0] n_window [WINDOW_LEN];

    // Window after this byte is shifted in
    always_comb begin
        for (int i = 0; i < WINDOW_LEN - 1; i++)
            n_window[i] = r_window[i + 1];
        n_window[WINDOW_LEN - 1] = i_data;
    end

    // Command decode: trailing three bytes all marker
    always_comb begin
        o_cmd          = '0;
        o_cmd.wr_idx   = n_window[0][IDX_W-1:0];
        o_cmd.wr_value = {n_window[2], n_window[1]};
        if (i_shift && n_window[3] == MARK_BYTE && n_window[4] == MARK_BYTE &&
            n_window[5] == MARK_BYTE) begin
            if (n_window[0] < 8'(SECTOR_COUNT)) begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.status = MAP_DONE;
            end else begin
                o_cmd.status = MAP_REJECTED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++)
                r_window[i] <= 8'd0;
        end else if (i_shift) begin
            for (int i = 0; i < WINDOW_LEN; i++)
                r_window[i] <= n_window[i];
        end
    end

endmodule

`default_nettype wire
